@@ sv/nearest_neighbor_pixel_scaler_assert.svh @@
// Assertion macros shared by the scaler RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef NEAREST_NEIGHBOR_PIXEL_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_PIXEL_SCALER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define NNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaler check failed");

// Next-cycle implication, off during reset.
`define NNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaler check failed");

`endif

@@ sv/nns_pkg.sv @@
// Types and constants for the nearest-neighbour pixel scaler.
// No dependencies; used by every other file but the assertion header, through scoped names.
package nns_pkg;

    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DIM_W);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [PIX_W-1:0]   t_pixel;

    localparam logic [DIV_CNT_W-1:0] DIV_STEP_LAST = DIV_CNT_W'(DIM_W - 1);

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_TGT_WIDTH  = 2'd2,
        CFG_TGT_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_LOAD_COL,
        DIV_RUN_COL,
        DIV_LOAD_ROW,
        DIV_RUN_ROW
    } t_div_state;

    // Effective (clamped) frame dimensions
    typedef struct packed {
        t_dim sw;
        t_dim sh;
        t_dim tw;
        t_dim th;
    } t_dims;

    // Step ratios: source size over target size, quotient and remainder
    typedef struct packed {
        t_dim col_q;
        t_dim col_r;
        t_dim row_q;
        t_dim row_r;
    } t_ratio;

    // Selected pixel as queued between front and back
    typedef struct packed {
        t_pixel pixel;
        t_dim   dcol;
        t_dim   drow;
        logic   col_last;
        logic   row_last;
    } t_result;

    localparam t_dim SRC_WIDTH_RST  = t_dim'(1024);
    localparam t_dim SRC_HEIGHT_RST = t_dim'(768);
    localparam t_dim TGT_WIDTH_RST  = t_dim'(1024);
    localparam t_dim TGT_HEIGHT_RST = t_dim'(768);

    // Clamp a register to 1..max_v; zero counts as one
    function automatic t_dim clamp_dim(input t_dim v, input logic [DIM_W:0] max_v);
        t_dim res;
        res = v;
        if (v == '0) begin
            res = t_dim'(1);
        end else if ({1'b0, v} > max_v) begin
            res = max_v[DIM_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ sv/nns_in_if.sv @@
// Source pixel channel: valid/ready plus pixel and frame start.
// Depends on nns_pkg.
interface nns_in_if;
    logic                  valid;
    logic                  ready;
    nns_pkg::t_pixel       pixel_bgra;
    logic                  frame_start;

    modport source (output valid, output pixel_bgra, output frame_start, input ready);
    modport sink   (input valid, input pixel_bgra, input frame_start, output ready);
endinterface

@@ sv/nns_out_if.sv @@
// Scaled pixel channel: valid/ready plus pixel, coordinates and last mark.
// Depends on nns_pkg.
interface nns_out_if;
    logic                  valid;
    logic                  ready;
    nns_pkg::t_pixel       pixel_out;
    nns_pkg::t_coord       dest_column;
    nns_pkg::t_coord       dest_row;
    logic                  frame_last;

    modport source (output valid, output pixel_out, output dest_column,
                    output dest_row, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input dest_column,
                    input dest_row, input frame_last, output ready);
endinterface

@@ sv/nns_div.sv @@
// Shared restoring divider: source/target ratios for columns then rows.
// Depends on nns_pkg.
module nns_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  nns_pkg::t_dims  i_dims,
    output logic            o_busy,
    output nns_pkg::t_ratio o_ratio
);

    nns_pkg::t_div_state               r_state, n_state;
    logic [nns_pkg::DIV_CNT_W-1:0]     r_cnt;
    nns_pkg::t_dim                     r_quo, r_rem;
    nns_pkg::t_dim                     r_col_q, r_col_r, r_row_q, r_row_r;

    nns_pkg::t_dim                     w_divisor;
    logic [nns_pkg::DIM_W:0]           w_rem_sh, w_rem_new;
    logic                              w_ge;
    nns_pkg::t_dim                     w_quo_new;
    logic                              w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nns_pkg::DIV_LOAD_COL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nns_pkg::DIV_IDLE:     n_state = nns_pkg::DIV_IDLE;
            nns_pkg::DIV_LOAD_COL: n_state = nns_pkg::DIV_RUN_COL;
            nns_pkg::DIV_RUN_COL: begin
                if (w_last) n_state = nns_pkg::DIV_LOAD_ROW;
            end
            nns_pkg::DIV_LOAD_ROW: n_state = nns_pkg::DIV_RUN_ROW;
            nns_pkg::DIV_RUN_ROW: begin
                if (w_last) n_state = nns_pkg::DIV_IDLE;
            end
            default:               n_state = nns_pkg::DIV_IDLE;
        endcase
        if (i_start) n_state = nns_pkg::DIV_LOAD_COL;
    end

    // one quotient bit per cycle
    always_comb begin
        w_last    = (r_cnt == nns_pkg::DIV_STEP_LAST);
        w_divisor = (r_state == nns_pkg::DIV_RUN_ROW) ? i_dims.th : i_dims.tw;
        w_rem_sh  = {r_rem, r_quo[nns_pkg::DIM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, w_divisor});
        w_rem_new = w_ge ? (w_rem_sh - {1'b0, w_divisor}) : w_rem_sh;
        w_quo_new = {r_quo[nns_pkg::DIM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == nns_pkg::DIV_RUN_COL || r_state == nns_pkg::DIV_RUN_ROW) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            nns_pkg::DIV_LOAD_COL: begin
                r_quo <= i_dims.sw;
                r_rem <= '0;
            end
            nns_pkg::DIV_LOAD_ROW: begin
                r_quo <= i_dims.sh;
                r_rem <= '0;
            end
            nns_pkg::DIV_RUN_COL: begin
                r_quo <= w_quo_new;
                r_rem <= w_rem_new[nns_pkg::DIM_W-1:0];
                if (w_last) begin
                    r_col_q <= w_quo_new;
                    r_col_r <= w_rem_new[nns_pkg::DIM_W-1:0];
                end
            end
            nns_pkg::DIV_RUN_ROW: begin
                r_quo <= w_quo_new;
                r_rem <= w_rem_new[nns_pkg::DIM_W-1:0];
                if (w_last) begin
                    r_row_q <= w_quo_new;
                    r_row_r <= w_rem_new[nns_pkg::DIM_W-1:0];
                end
            end
            default: begin
                r_quo <= r_quo;
            end
        endcase
    end

    assign o_busy  = (r_state != nns_pkg::DIV_IDLE);
    assign o_ratio = '{col_q: r_col_q, col_r: r_col_r, row_q: r_row_q, row_r: r_row_r};

endmodule

@@ sv/nns_front.sv @@
// Front end: accepts source pixels, tracks source/destination counters and
// picks the selected ones. Depends on nns_pkg and nns_in_if.
module nns_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_busy,
    input  logic              i_room,
    input  nns_pkg::t_dims    i_dims,
    input  nns_pkg::t_ratio   i_ratio,
    nns_in_if.sink            i_pix,
    output logic              o_push,
    output nns_pkg::t_result  o_result
);

    nns_pkg::t_dim r_scol, r_srow, r_dcc, r_drc, r_ncol, r_nrow, r_crem, r_rrem;
    nns_pkg::t_dim n_scol, n_srow, n_dcc, n_drc, n_ncol, n_nrow, n_crem, n_rrem;
    nns_pkg::t_dim c_scol, c_srow, c_dcc, c_drc, c_ncol, c_nrow, c_crem, c_rrem;

    logic                    w_accept, w_row_sel, w_col_sel, w_col_end, w_row_end;
    logic                    w_cwrap, w_rwrap;
    logic [nns_pkg::DIM_W:0] w_csum, w_rsum, w_scol_inc, w_srow_inc;
    logic [nns_pkg::DIM_W:0] w_dcc_inc, w_drc_inc;

    assign i_pix.ready = !i_busy && i_room;
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_comb begin
        // frame start wipes the state before this pixel is looked at
        c_scol = i_pix.frame_start ? '0 : r_scol;
        c_srow = i_pix.frame_start ? '0 : r_srow;
        c_dcc  = i_pix.frame_start ? '0 : r_dcc;
        c_drc  = i_pix.frame_start ? '0 : r_drc;
        c_ncol = i_pix.frame_start ? '0 : r_ncol;
        c_nrow = i_pix.frame_start ? '0 : r_nrow;
        c_crem = i_pix.frame_start ? '0 : r_crem;
        c_rrem = i_pix.frame_start ? '0 : r_rrem;

        w_row_sel = (c_srow == c_nrow) && (c_drc < i_dims.th);
        w_col_sel = (c_scol == c_ncol) && (c_dcc < i_dims.tw);

        w_dcc_inc  = {1'b0, c_dcc} + 1'b1;
        w_drc_inc  = {1'b0, c_drc} + 1'b1;
        w_scol_inc = {1'b0, c_scol} + 1'b1;
        w_srow_inc = {1'b0, c_srow} + 1'b1;
        w_col_end  = (w_scol_inc >= {1'b0, i_dims.sw});
        w_row_end  = (w_srow_inc >= {1'b0, i_dims.sh});

        w_csum  = {1'b0, c_crem} + {1'b0, i_ratio.col_r};
        w_rsum  = {1'b0, c_rrem} + {1'b0, i_ratio.row_r};
        w_cwrap = (w_csum >= {1'b0, i_dims.tw});
        w_rwrap = (w_rsum >= {1'b0, i_dims.th});

        n_scol = r_scol; n_srow = r_srow; n_dcc  = r_dcc;  n_drc  = r_drc;
        n_ncol = r_ncol; n_nrow = r_nrow; n_crem = r_crem; n_rrem = r_rrem;

        if (w_accept) begin
            n_scol = w_scol_inc[nns_pkg::DIM_W-1:0];
            n_srow = c_srow; n_dcc  = c_dcc;  n_drc  = c_drc;
            n_ncol = c_ncol; n_nrow = c_nrow; n_crem = c_crem; n_rrem = c_rrem;
            if (w_col_sel) begin
                n_dcc  = w_dcc_inc[nns_pkg::DIM_W-1:0];
                n_ncol = c_ncol + i_ratio.col_q + nns_pkg::t_dim'(w_cwrap);
                n_crem = w_cwrap ? (w_csum[nns_pkg::DIM_W-1:0] - i_dims.tw)
                                 : w_csum[nns_pkg::DIM_W-1:0];
            end
            if (w_col_end) begin
                n_scol = '0; n_dcc = '0; n_ncol = '0; n_crem = '0;
                if (w_row_sel) begin
                    n_drc  = w_drc_inc[nns_pkg::DIM_W-1:0];
                    n_nrow = c_nrow + i_ratio.row_q + nns_pkg::t_dim'(w_rwrap);
                    n_rrem = w_rwrap ? (w_rsum[nns_pkg::DIM_W-1:0] - i_dims.th)
                                     : w_rsum[nns_pkg::DIM_W-1:0];
                end
                n_srow = w_srow_inc[nns_pkg::DIM_W-1:0];
                if (w_row_end) begin
                    // end of the source frame: wrap into a fresh frame
                    n_srow = '0; n_drc = '0; n_nrow = '0; n_rrem = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_scol <= '0; r_srow <= '0; r_dcc  <= '0; r_drc  <= '0;
            r_ncol <= '0; r_nrow <= '0; r_crem <= '0; r_rrem <= '0;
        end else begin
            r_scol <= n_scol; r_srow <= n_srow; r_dcc  <= n_dcc;  r_drc  <= n_drc;
            r_ncol <= n_ncol; r_nrow <= n_nrow; r_crem <= n_crem; r_rrem <= n_rrem;
        end
    end

    assign o_push            = w_accept && w_row_sel && w_col_sel;
    assign o_result.pixel    = i_pix.pixel_bgra;
    assign o_result.dcol     = c_dcc;
    assign o_result.drow     = c_drc;
    assign o_result.col_last = (w_dcc_inc == {1'b0, i_dims.tw});
    assign o_result.row_last = (w_drc_inc == {1'b0, i_dims.th});

endmodule

@@ sv/nns_fifo.sv @@
// Short result queue between front end and output stage.
// Depends on nns_pkg and the assertion header.
`include "nearest_neighbor_pixel_scaler_assert.svh"

module nns_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nns_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output nns_pkg::t_result o_head
);

    nns_pkg::t_result                r_mem [nns_pkg::FIFO_DEPTH];
    logic [nns_pkg::FIFO_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [nns_pkg::FIFO_AW:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_room  = (r_count < (nns_pkg::FIFO_AW+1)'(nns_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    `NNS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= (nns_pkg::FIFO_AW+1)'(nns_pkg::FIFO_DEPTH))
    `NNS_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `NNS_ASSERT_NXT(a_push_counts, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

@@ sv/nns_back.sv @@
// Output stage: pops the queue into a registered output and forms the
// last-of-frame mark. Depends on nns_pkg and nns_out_if.
module nns_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  nns_pkg::t_result i_head,
    output logic             o_pop,
    nns_out_if.source        o_pix
);

    logic            r_valid;
    nns_pkg::t_pixel r_pixel;
    nns_pkg::t_coord r_dcol, r_drow;
    logic            r_last;

    assign o_pop = i_valid && (!r_valid || o_pix.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_pix.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel <= i_head.pixel;
            r_dcol  <= i_head.dcol[nns_pkg::COORD_W-1:0];
            r_drow  <= i_head.drow[nns_pkg::COORD_W-1:0];
            r_last  <= i_head.col_last && i_head.row_last;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.pixel_out   = r_pixel;
    assign o_pix.dest_column = r_dcol;
    assign o_pix.dest_row    = r_drow;
    assign o_pix.frame_last  = r_last;

endmodule

@@ sv/nearest_neighbor_pixel_scaler.sv @@
// Nearest-neighbour downscaler for a raster BGRA pixel stream. Once running it
// takes one source pixel per clock while the queue has room and passes on
// those that land on a selected destination position, each with its
// destination column and row and a mark on the last pixel of the scaled
// frame. The front end is combinational; a selected pixel reaches the output
// through the queue and the output register. After reset and after every
// configuration write the ratio divider works out source/target quotient and
// remainder for columns and then rows, one bit per cycle, with ready low while
// it works. A configuration write also restarts the frame, as does frame_start
// on a pixel. Targets larger than the source are clamped to the source size,
// and every dimension is clamped to 1..MAX_DIMENSION. The four-entry queue and
// output register let the front end keep taking pixels while a result waits
// at the output. Depends on nns_pkg, nns_in_if, nns_out_if, nns_div,
// nns_front, nns_fifo, nns_back and the assertion header.
`include "nearest_neighbor_pixel_scaler_assert.svh"

module nearest_neighbor_pixel_scaler #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    nns_in_if.sink                 i_pix,
    nns_out_if.source              o_pix,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_index,
    input  nns_pkg::t_dim          i_cfg_data
);

    localparam logic [nns_pkg::DIM_W:0] MAX_DIM = (nns_pkg::DIM_W+1)'(MAX_DIMENSION);

    // configuration registers, raw as written
    nns_pkg::t_dim    r_src_width, r_src_height, r_tgt_width, r_tgt_height;

    nns_pkg::t_dims   w_dims;
    nns_pkg::t_ratio  w_ratio;
    nns_pkg::t_result w_result, w_head;
    nns_pkg::t_dim    w_sw, w_sh, w_tw, w_th;
    logic             w_busy, w_push, w_room, w_fifo_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= nns_pkg::SRC_WIDTH_RST;
            r_src_height <= nns_pkg::SRC_HEIGHT_RST;
            r_tgt_width  <= nns_pkg::TGT_WIDTH_RST;
            r_tgt_height <= nns_pkg::TGT_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (nns_pkg::t_cfg_idx'(i_cfg_index))
                nns_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                nns_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                nns_pkg::CFG_TGT_WIDTH:  r_tgt_width  <= i_cfg_data;
                nns_pkg::CFG_TGT_HEIGHT: r_tgt_height <= i_cfg_data;
                default:                 r_src_width  <= r_src_width;
            endcase
        end
    end

    // effective sizes: clamp to range, then no upscale
    always_comb begin
        w_sw = nns_pkg::clamp_dim(r_src_width,  MAX_DIM);
        w_sh = nns_pkg::clamp_dim(r_src_height, MAX_DIM);
        w_tw = nns_pkg::clamp_dim(r_tgt_width,  MAX_DIM);
        w_th = nns_pkg::clamp_dim(r_tgt_height, MAX_DIM);
        if (w_tw > w_sw) w_tw = w_sw;
        if (w_th > w_sh) w_th = w_sh;
        w_dims = '{sw: w_sw, sh: w_sh, tw: w_tw, th: w_th};
    end

    // every write touches a listed register, so each one restarts
    nns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_wr_en),
        .i_dims  (w_dims),
        .o_busy  (w_busy),
        .o_ratio (w_ratio)
    );

    nns_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_wr_en),
        .i_busy   (w_busy),
        .i_room   (w_room),
        .i_dims   (w_dims),
        .i_ratio  (w_ratio),
        .i_pix    (i_pix),
        .o_push   (w_push),
        .o_result (w_result)
    );

    nns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (w_fifo_valid),
        .o_head  (w_head)
    );

    nns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fifo_valid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_pix   (o_pix)
    );

    `NNS_ASSERT_IMP(a_no_accept_while_div, i_clk, i_rst_n, i_pix.valid && i_pix.ready, !w_busy)
    `NNS_ASSERT_NXT(a_cfg_restarts_div, i_clk, i_rst_n, i_cfg_wr_en, w_busy)
    `NNS_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, w_push, w_room)

endmodule
